### hdl/qrp_pkg.sv
// types, widths and rounding functions shared by the relative pose blocks
package qrp_pkg;

  localparam int POS_W = 24;
  localparam int QUAT_W = 16;
  localparam int D_W = POS_W + 1;
  localparam int P_W = QUAT_W + 1;
  localparam int HP_W = QUAT_W + P_W;
  localparam int HS_W = HP_W + 2;
  localparam int SQ_W = 2 * P_W;
  localparam int K_W = SQ_W + 2;
  localparam int PD_W = P_W + D_W;
  localparam int DOT_W = PD_W + 2;
  localparam int CR_W = PD_W + 1;
  localparam int KD_W = K_W + D_W;
  localparam int DP_W = DOT_W + P_W;
  localparam int WT_W = P_W + CR_W;
  localparam int SUM_W = 64;
  localparam int NUM_STAGES = 5;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_QX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_QY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_QZ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_QW = 3'd6;

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

  typedef struct packed {
    logic signed [POS_W-1:0]  cur_x;
    logic signed [POS_W-1:0]  cur_y;
    logic signed [POS_W-1:0]  cur_z;
    logic signed [QUAT_W-1:0] cur_qx;
    logic signed [QUAT_W-1:0] cur_qy;
    logic signed [QUAT_W-1:0] cur_qz;
    logic signed [QUAT_W-1:0] cur_qw;
  } pose_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  rel_x;
    logic signed [POS_W-1:0]  rel_y;
    logic signed [POS_W-1:0]  rel_z;
    logic signed [QUAT_W-1:0] rel_qx;
    logic signed [QUAT_W-1:0] rel_qy;
    logic signed [QUAT_W-1:0] rel_qz;
    logic signed [QUAT_W-1:0] rel_qw;
  } pose_out_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  x;
    logic signed [POS_W-1:0]  y;
    logic signed [POS_W-1:0]  z;
    logic signed [QUAT_W-1:0] qx;
    logic signed [QUAT_W-1:0] qy;
    logic signed [QUAT_W-1:0] qz;
    logic signed [QUAT_W-1:0] qw;
  } origin_t;

  // q6.28 to q1.14, round half up, clamp to +-1.0
  function automatic logic signed [QUAT_W-1:0] sat_quat(input logic signed [HS_W-1:0] v);
    logic signed [HS_W:0] r;
    logic signed [21:0]   s;
    r = (HS_W+1)'(v) + (HS_W+1)'(8192);
    s = 22'(r >>> 14);
    if (s > 22'sd16384) begin
      return QUAT_ONE;
    end else if (s < -22'sd16384) begin
      return -QUAT_ONE;
    end
    return QUAT_W'(s);
  endfunction

  // drop the 2^28 scale of two q1.14 factors, round half up, clamp to q7.16
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    logic signed [35:0]      s;
    r = v + 64'sd134217728;
    s = 36'(r >>> 28);
    if (s > 36'sd8388607) begin
      return 24'sh7fffff;
    end else if (s < -36'sd8388608) begin
      return 24'sh800000;
    end
    return POS_W'(s);
  endfunction

endpackage

### hdl/qrp_core.sv
// five stage datapath: relative rotation and rotated translation with stall control
module qrp_core import qrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  origin_t   origin_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  pose_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pose_out_t out_data_o
);

  logic [NUM_STAGES:1] vld_q, vld_d;
  logic [NUM_STAGES:1] rdy;

  // stage 1: position difference, conjugate of origin
  logic signed [D_W-1:0]    s1_d_d [3];
  logic signed [D_W-1:0]    s1_d_q [3];
  logic signed [P_W-1:0]    s1_p_d [4];
  logic signed [P_W-1:0]    s1_p_q [4];
  logic signed [QUAT_W-1:0] s1_a_d [4];
  logic signed [QUAT_W-1:0] s1_a_q [4];

  // stage 2: all first level products
  logic signed [HP_W-1:0] s2_hp_d [4][4];
  logic signed [HP_W-1:0] s2_hp_q [4][4];
  logic signed [PD_W-1:0] s2_pd_d [3][3];
  logic signed [PD_W-1:0] s2_pd_q [3][3];
  logic signed [SQ_W-1:0] s2_sq_d [4];
  logic signed [SQ_W-1:0] s2_sq_q [4];
  logic signed [D_W-1:0]  s2_d_q [3];
  logic signed [P_W-1:0]  s2_p_q [4];

  // stage 3: sums, finished rotation
  logic signed [K_W-1:0]    s3_k_d, s3_k_q;
  logic signed [DOT_W-1:0]  s3_dot_d, s3_dot_q;
  logic signed [CR_W-1:0]   s3_t_d [3];
  logic signed [CR_W-1:0]   s3_t_q [3];
  logic signed [QUAT_W-1:0] s3_qo_d [4];
  logic signed [QUAT_W-1:0] s3_qo_q [4];
  logic signed [D_W-1:0]    s3_d_q [3];
  logic signed [P_W-1:0]    s3_p_q [4];

  // stage 4: second level products
  logic signed [KD_W-1:0]   s4_kd_d [3];
  logic signed [KD_W-1:0]   s4_kd_q [3];
  logic signed [DP_W-1:0]   s4_dp_d [3];
  logic signed [DP_W-1:0]   s4_dp_q [3];
  logic signed [WT_W-1:0]   s4_wt_d [3];
  logic signed [WT_W-1:0]   s4_wt_q [3];
  logic signed [QUAT_W-1:0] s4_qo_q [4];

  // stage 5: output register
  pose_out_t s5_out_d, s5_out_q;

  logic signed [SUM_W-1:0] s5_sum [3];
  logic signed [HS_W-1:0]  s3_hs [4];

  // handshake chain
  always_comb begin
    rdy[NUM_STAGES] = !vld_q[NUM_STAGES] || !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d = vld_q;
    if (rdy[1]) begin
      vld_d[1] = in_valid_i;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = vld_q[NUM_STAGES];
  assign out_data_o  = s5_out_q;

  // stage 1
  always_comb begin
    s1_d_d[0] = D_W'(in_data_i.cur_x) - D_W'(origin_i.x);
    s1_d_d[1] = D_W'(in_data_i.cur_y) - D_W'(origin_i.y);
    s1_d_d[2] = D_W'(in_data_i.cur_z) - D_W'(origin_i.z);
    s1_p_d[0] = -P_W'(origin_i.qx);
    s1_p_d[1] = -P_W'(origin_i.qy);
    s1_p_d[2] = -P_W'(origin_i.qz);
    s1_p_d[3] = P_W'(origin_i.qw);
    s1_a_d[0] = in_data_i.cur_qx;
    s1_a_d[1] = in_data_i.cur_qy;
    s1_a_d[2] = in_data_i.cur_qz;
    s1_a_d[3] = in_data_i.cur_qw;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_d_q <= s1_d_d;
      s1_p_q <= s1_p_d;
      s1_a_q <= s1_a_d;
    end
  end

  // stage 2
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        s2_hp_d[i][j] = HP_W'(s1_a_q[i]) * HP_W'(s1_p_q[j]);
      end
      s2_sq_d[i] = SQ_W'(s1_p_q[i]) * SQ_W'(s1_p_q[i]);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s2_pd_d[i][j] = PD_W'(s1_p_q[i]) * PD_W'(s1_d_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_hp_q <= s2_hp_d;
      s2_pd_q <= s2_pd_d;
      s2_sq_q <= s2_sq_d;
      s2_d_q  <= s1_d_q;
      s2_p_q  <= s1_p_q;
    end
  end

  // stage 3, products indexed [a part][p part] with x y z w as 0..3
  always_comb begin
    s3_k_d = K_W'(s2_sq_q[3]) - K_W'(s2_sq_q[0]) - K_W'(s2_sq_q[1]) - K_W'(s2_sq_q[2]);
    s3_dot_d = DOT_W'(s2_pd_q[0][0]) + DOT_W'(s2_pd_q[1][1]) + DOT_W'(s2_pd_q[2][2]);
    s3_t_d[0] = CR_W'(s2_pd_q[1][2]) - CR_W'(s2_pd_q[2][1]);
    s3_t_d[1] = CR_W'(s2_pd_q[2][0]) - CR_W'(s2_pd_q[0][2]);
    s3_t_d[2] = CR_W'(s2_pd_q[0][1]) - CR_W'(s2_pd_q[1][0]);
    s3_hs[0] = HS_W'(s2_hp_q[3][0]) + HS_W'(s2_hp_q[0][3])
             + HS_W'(s2_hp_q[1][2]) - HS_W'(s2_hp_q[2][1]);
    s3_hs[1] = HS_W'(s2_hp_q[3][1]) - HS_W'(s2_hp_q[0][2])
             + HS_W'(s2_hp_q[1][3]) + HS_W'(s2_hp_q[2][0]);
    s3_hs[2] = HS_W'(s2_hp_q[3][2]) + HS_W'(s2_hp_q[0][1])
             - HS_W'(s2_hp_q[1][0]) + HS_W'(s2_hp_q[2][3]);
    s3_hs[3] = HS_W'(s2_hp_q[3][3]) - HS_W'(s2_hp_q[0][0])
             - HS_W'(s2_hp_q[1][1]) - HS_W'(s2_hp_q[2][2]);
    for (int i = 0; i < 4; i++) begin
      s3_qo_d[i] = sat_quat(s3_hs[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_k_q   <= s3_k_d;
      s3_dot_q <= s3_dot_d;
      s3_t_q   <= s3_t_d;
      s3_qo_q  <= s3_qo_d;
      s3_d_q   <= s2_d_q;
      s3_p_q   <= s2_p_q;
    end
  end

  // stage 4
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_kd_d[i] = KD_W'(s3_k_q) * KD_W'(s3_d_q[i]);
      s4_dp_d[i] = DP_W'(s3_dot_q) * DP_W'(s3_p_q[i]);
      s4_wt_d[i] = WT_W'(s3_p_q[3]) * WT_W'(s3_t_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_kd_q <= s4_kd_d;
      s4_dp_q <= s4_dp_d;
      s4_wt_q <= s4_wt_d;
      s4_qo_q <= s3_qo_q;
    end
  end

  // stage 5
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s5_sum[i] = SUM_W'(s4_kd_q[i]) + (SUM_W'(s4_dp_q[i]) <<< 1)
                + (SUM_W'(s4_wt_q[i]) <<< 1);
    end
    s5_out_d.rel_x  = sat_pos(s5_sum[0]);
    s5_out_d.rel_y  = sat_pos(s5_sum[1]);
    s5_out_d.rel_z  = sat_pos(s5_sum[2]);
    s5_out_d.rel_qx = s4_qo_q[0];
    s5_out_d.rel_qy = s4_qo_q[1];
    s5_out_d.rel_qz = s4_qo_q[2];
    s5_out_d.rel_qw = s4_qo_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_out_q <= s5_out_d;
    end
  end

endmodule

### hdl/quaternion_relative_pose_unit.sv
// top level: origin pose registers and the relative pose pipeline
//
// Takes one pose per clock while the input is not stalled and returns its pose
// relative to the programmed origin: rotation cur_q * conj(origin_q), translation
// (cur - origin) rotated by conj(origin_q), both rounded and saturated. The
// datapath has five register stages (difference, products, sums, second
// products, final sum and output register), and one pose can be taken every
// cycle while the input is not stalled. A stall on the output only holds the
// input when every stage is full; empty stages are filled meanwhile. Origin
// registers reset to the identity pose; the user must write them only while no
// pose is in flight, as the block itself does not enforce this.
module quaternion_relative_pose_unit import qrp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pose_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pose_out_t             out_data_o
);

  origin_t origin_q, origin_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    origin_d = origin_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_ORIGIN_X:  origin_d.x  = cfg_data_i[POS_W-1:0];
        REG_ORIGIN_Y:  origin_d.y  = cfg_data_i[POS_W-1:0];
        REG_ORIGIN_Z:  origin_d.z  = cfg_data_i[POS_W-1:0];
        REG_ORIGIN_QX: origin_d.qx = cfg_data_i[QUAT_W-1:0];
        REG_ORIGIN_QY: origin_d.qy = cfg_data_i[QUAT_W-1:0];
        REG_ORIGIN_QZ: origin_d.qz = cfg_data_i[QUAT_W-1:0];
        REG_ORIGIN_QW: origin_d.qw = cfg_data_i[QUAT_W-1:0];
        default: begin
          origin_d = origin_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= '{x: '0, y: '0, z: '0, qx: '0, qy: '0, qz: '0, qw: QUAT_ONE};
    end else begin
      origin_q <= origin_d;
    end
  end

  qrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .origin_i    (origin_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/qrp_checker.sv
// port level checks for the relative pose unit and their bind
module qrp_checker import qrp_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      cfg_ready_o,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input pose_out_t out_data_o
);

  // a stalled result transaction stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a free output drains the whole pipeline, so input is never held
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input held while output free");

  // an empty output register always leaves room for a new pose
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input held with empty output");

  // input can only become held while the output is stalled with a result waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> out_valid_o && out_stall_i)
    else $error("input stall without output backpressure");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind quaternion_relative_pose_unit qrp_checker u_qrp_checker (.*);

### tb/sv/qrp_pose_checker.sv
// transaction monitor, relative pose predictor and result comparison
`timescale 1ns / 1ps
module qrp_pose_checker import qrp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  pose_in_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  pose_out_t             out_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  localparam int MAX_REPORTS = 10;
  localparam longint Q_ONE = 16384;
  localparam longint POS_HI = 8388607;
  localparam longint POS_LO = -8388608;

  origin_t   origin_regs;
  pose_out_t rel_pose_q[$];
  pose_out_t expected_pose;
  int        mismatches = 0;

  function automatic logic signed [QUAT_W-1:0] round_quat(input longint v);
    longint r;
    r = (v + 64'sd8192) >>> 14;
    if (r > Q_ONE) begin
      r = Q_ONE;
    end else if (r < -Q_ONE) begin
      r = -Q_ONE;
    end
    return QUAT_W'(r);
  endfunction

  function automatic logic signed [POS_W-1:0] round_pos(input longint v);
    longint r;
    r = (v + 64'sd134217728) >>> 28;
    if (r > POS_HI) begin
      r = POS_HI;
    end else if (r < POS_LO) begin
      r = POS_LO;
    end
    return POS_W'(r);
  endfunction

  // rotation cur_q * conj(origin_q), translation conj(origin_q) * d * origin_q
  function automatic pose_out_t relative_pose(input pose_in_t cur, input origin_t org);
    longint dx, dy, dz, ux, uy, uz, w, ax, ay, az, aw, k, dot, crx, cry, crz;
    pose_out_t rel;
    dx = longint'(cur.cur_x) - longint'(org.x);
    dy = longint'(cur.cur_y) - longint'(org.y);
    dz = longint'(cur.cur_z) - longint'(org.z);
    ux = -longint'(org.qx);
    uy = -longint'(org.qy);
    uz = -longint'(org.qz);
    w  = longint'(org.qw);
    ax = longint'(cur.cur_qx);
    ay = longint'(cur.cur_qy);
    az = longint'(cur.cur_qz);
    aw = longint'(cur.cur_qw);
    k   = w * w - (ux * ux + uy * uy + uz * uz);
    dot = ux * dx + uy * dy + uz * dz;
    crx = uy * dz - uz * dy;
    cry = uz * dx - ux * dz;
    crz = ux * dy - uy * dx;
    rel.rel_x  = round_pos(k * dx + 2 * dot * ux + 2 * w * crx);
    rel.rel_y  = round_pos(k * dy + 2 * dot * uy + 2 * w * cry);
    rel.rel_z  = round_pos(k * dz + 2 * dot * uz + 2 * w * crz);
    rel.rel_qx = round_quat(aw * ux + ax * w + ay * uz - az * uy);
    rel.rel_qy = round_quat(aw * uy - ax * uz + ay * w + az * ux);
    rel.rel_qz = round_quat(aw * uz + ax * uy - ay * ux + az * w);
    rel.rel_qw = round_quat(aw * w - ax * ux - ay * uy - az * uz);
    return rel;
  endfunction

  function automatic string pose_str(input pose_out_t p);
    return $sformatf("x=%0d y=%0d z=%0d qx=%0d qy=%0d qz=%0d qw=%0d",
                     p.rel_x, p.rel_y, p.rel_z, p.rel_qx, p.rel_qy, p.rel_qz, p.rel_qw);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_regs = '0;
      origin_regs.qw = QUAT_ONE;
      rel_pose_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rel_pose_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result with no pose pending: %s", $time, pose_str(out_data_i));
          end
        end else begin
          expected_pose = rel_pose_q.pop_front();
          if (out_data_i.rel_x !== expected_pose.rel_x ||
              out_data_i.rel_y !== expected_pose.rel_y ||
              out_data_i.rel_z !== expected_pose.rel_z ||
              out_data_i.rel_qx !== expected_pose.rel_qx ||
              out_data_i.rel_qy !== expected_pose.rel_qy ||
              out_data_i.rel_qz !== expected_pose.rel_qz ||
              out_data_i.rel_qw !== expected_pose.rel_qw) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: relative pose mismatch: expected %s, actual %s", $time,
                       pose_str(expected_pose), pose_str(out_data_i));
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_ORIGIN_X: begin
            origin_regs.x = cfg_data_i;
          end
          REG_ORIGIN_Y: begin
            origin_regs.y = cfg_data_i;
          end
          REG_ORIGIN_Z: begin
            origin_regs.z = cfg_data_i;
          end
          REG_ORIGIN_QX: begin
            origin_regs.qx = cfg_data_i[QUAT_W-1:0];
          end
          REG_ORIGIN_QY: begin
            origin_regs.qy = cfg_data_i[QUAT_W-1:0];
          end
          REG_ORIGIN_QZ: begin
            origin_regs.qz = cfg_data_i[QUAT_W-1:0];
          end
          REG_ORIGIN_QW: begin
            origin_regs.qw = cfg_data_i[QUAT_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        rel_pose_q.push_back(relative_pose(in_data_i, origin_regs));
      end
    end
    pending_o <= rel_pose_q.size();
    mismatch_count_o <= mismatches;
  end

endmodule

### tb/sv/tb_top.sv
// clock, reset, pose and origin stimulus, and pass/fail verdict for the relative pose unit
`timescale 1ns / 1ps
module tb_top;
  import qrp_pkg::*;

  localparam int POS_MAX = 8388607;
  localparam int POS_MIN = -8388608;
  localparam int Q_ONE = 16384;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int PRESSURE_CYCLES = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT = 5000;
  localparam longint LIMIT_NS = 10_000_000;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] x, y, z, w;
  } quat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pose_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pose_out_t             out_data;
  int                    mismatches;
  int                    pending;
  bit                    sender_gaps_on = 1'b1;
  bit                    pressure_req = 1'b0;

  quaternion_relative_pose_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  qrp_pose_checker pose_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pose_in_t make_pose(input int x, input int y, input int z, input int qx,
                                         input int qy, input int qz, input int qw);
    pose_in_t p;
    p.cur_x  = POS_W'(x);
    p.cur_y  = POS_W'(y);
    p.cur_z  = POS_W'(z);
    p.cur_qx = QUAT_W'(qx);
    p.cur_qy = QUAT_W'(qy);
    p.cur_qz = QUAT_W'(qz);
    p.cur_qw = QUAT_W'(qw);
    return p;
  endfunction

  function automatic origin_t make_origin(input int x, input int y, input int z, input int qx,
                                          input int qy, input int qz, input int qw);
    origin_t o;
    o.x  = POS_W'(x);
    o.y  = POS_W'(y);
    o.z  = POS_W'(z);
    o.qx = QUAT_W'(qx);
    o.qy = QUAT_W'(qy);
    o.qz = QUAT_W'(qz);
    o.qw = QUAT_W'(qw);
    return o;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return POS_W'($urandom);
    end
    if (r < 85) begin
      return POS_W'(int'($urandom_range(0, 524288)) - 262144);
    end
    case ($urandom_range(0, 4))
      0: return POS_W'(POS_MAX);
      1: return POS_W'(POS_MIN);
      2: return '0;
      3: return '1;
      default: return POS_W'(1);
    endcase
  endfunction

  // mostly unit quaternions, some in range, some raw bit patterns
  function automatic quat_t rand_quat();
    real a[4];
    real n;
    int r;
    quat_t q;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      do begin
        n = 0.0;
        foreach (a[i]) begin
          a[i] = real'($urandom_range(0, 2000)) - 1000.0;
          n += a[i] * a[i];
        end
      end while (n < 1.0);
      n = $sqrt(n);
      q.x = QUAT_W'($rtoi(a[0] / n * Q_ONE));
      q.y = QUAT_W'($rtoi(a[1] / n * Q_ONE));
      q.z = QUAT_W'($rtoi(a[2] / n * Q_ONE));
      q.w = QUAT_W'($rtoi(a[3] / n * Q_ONE));
    end else if (r < 85) begin
      q.x = QUAT_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
      q.y = QUAT_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
      q.z = QUAT_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
      q.w = QUAT_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
    end else begin
      q = quat_t'({$urandom, $urandom});
    end
    return q;
  endfunction

  function automatic pose_in_t rand_pose();
    pose_in_t p;
    quat_t q;
    q = rand_quat();
    p.cur_x  = rand_pos();
    p.cur_y  = rand_pos();
    p.cur_z  = rand_pos();
    p.cur_qx = q.x;
    p.cur_qy = q.y;
    p.cur_qz = q.z;
    p.cur_qw = q.w;
    return p;
  endfunction

  function automatic origin_t rand_origin();
    origin_t o;
    quat_t q;
    q = rand_quat();
    o.x  = rand_pos();
    o.y  = rand_pos();
    o.z  = rand_pos();
    o.qx = q.x;
    o.qy = q.y;
    o.qz = q.z;
    o.qw = q.w;
    return o;
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int stall_len(input bit stalling);
    int r;
    r = $urandom_range(0, 99);
    if (stalling) begin
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
    end
    if (r < 60) return $urandom_range(1, 6);
    if (r < 92) return $urandom_range(7, 30);
    return $urandom_range(100, 300);
  endfunction

  // quaternion registers get junk in the unused upper bits
  task automatic program_origin(input origin_t o, input bit poke_unused);
    reg_write_t plan[$];
    plan.push_back('{REG_ORIGIN_X, CFG_DATA_W'(o.x)});
    plan.push_back('{REG_ORIGIN_Y, CFG_DATA_W'(o.y)});
    plan.push_back('{REG_ORIGIN_Z, CFG_DATA_W'(o.z)});
    plan.push_back('{REG_ORIGIN_QX, {8'($urandom), o.qx}});
    plan.push_back('{REG_ORIGIN_QY, {8'($urandom), o.qy}});
    plan.push_back('{REG_ORIGIN_QZ, {8'($urandom), o.qz}});
    plan.push_back('{REG_ORIGIN_QW, {8'($urandom), o.qw}});
    if (poke_unused) begin
      plan.insert($urandom_range(0, plan.size()), '{REG_UNUSED, CFG_DATA_W'($urandom)});
    end
    foreach (plan[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= plan[i].idx;
      cfg_data  <= plan[i].data;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pose(input pose_in_t p);
    int gap;
    gap = sender_gaps_on ? sender_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    @(posedge clk);
    while (pending != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_batch(input pose_in_t poses[$]);
    foreach (poses[i]) begin
      if (i % 50 == 0) begin
        sender_gaps_on = ($urandom_range(0, 3) != 0);
      end
      send_pose(poses[i]);
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : output_stall
    int left;
    bit stall_now;
    left = 0;
    stall_now = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        stall_now = 1'b1;
        left = PRESSURE_CYCLES;
      end else if (left == 0) begin
        stall_now = !stall_now;
        left = stall_len(stall_now);
      end else begin
        left--;
      end
      out_stall <= stall_now;
    end
  end

  initial begin : stimulus
    pose_in_t poses[$];
    int ph;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity origin from reset
    poses = '{make_pose(0, 0, 0, 0, 0, 0, Q_ONE),
              make_pose(POS_MAX, POS_MIN, 0, Q_ONE, 0, 0, 0),
              make_pose(POS_MIN, POS_MAX, POS_MAX, 0, -Q_ONE, 0, 0),
              make_pose(-1, -1, -1, -32768, -32768, -32768, -32768),
              make_pose(1, 1, 1, 32767, 32767, 32767, 32767),
              make_pose(12345, -54321, 65536, 8192, 8192, 8192, 8192)};
    send_batch(poses);

    // extreme origin, out of range quaternion parts, saturation
    program_origin(make_origin(POS_MAX, POS_MIN, POS_MAX, -32768, 32767, Q_ONE, -32768), 1'b1);
    poses = '{make_pose(POS_MIN, POS_MAX, POS_MIN, 0, 0, 0, Q_ONE),
              make_pose(POS_MAX, POS_MAX, POS_MAX, -32768, -32768, -32768, -32768),
              make_pose(0, 0, 0, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE),
              make_pose(POS_MAX, POS_MIN, 0, 32767, 0, -32768, 0)};
    send_batch(poses);

    // half-scale origin quaternion puts some results exactly on rounding ties
    program_origin(make_origin(0, 0, 0, 0, 0, 0, Q_ONE / 2), 1'b0);
    poses = '{make_pose(2, -2, 1, 0, 0, 0, 1),
              make_pose(-2, 2, -6, 0, 0, 0, -1),
              make_pose(6, 0, 0, 1, -1, 3, -3)};
    send_batch(poses);

    // half turn about x with the origin at extreme x and y
    program_origin(make_origin(POS_MIN, POS_MAX, 0, Q_ONE, 0, 0, 0), 1'b0);
    poses = '{make_pose(POS_MAX, POS_MIN, POS_MIN, 0, 0, 0, Q_ONE),
              make_pose(0, 0, 0, 11585, 0, 0, 11585),
              make_pose(-1, 1, POS_MAX, 0, Q_ONE, 0, 0)};
    send_batch(poses);

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      program_origin(ph == 0 ? make_origin(0, 0, 0, 0, 0, 0, Q_ONE) : rand_origin(),
                     $urandom_range(0, 3) == 0);
      poses.delete();
      repeat (ITEMS_PER_PHASE) poses.push_back(rand_pose());
      if (ph == 2 || ph == 5) begin
        pressure_req = 1'b1;
      end
      send_batch(poses);
    end

    if (mismatches == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### filelist.f
hdl/qrp_pkg.sv
hdl/qrp_core.sv
hdl/quaternion_relative_pose_unit.sv
hdl/qrp_checker.sv
tb/sv/qrp_pose_checker.sv
tb/sv/tb_top.sv
